// File: design/tbcc_pkg.sv
// ----------------------------------------------------------------------------
// tbcc_pkg
// Shared types and codes for the two-button chord combiner.
// ----------------------------------------------------------------------------
package tbcc_pkg;

  localparam int ID_W   = 16;
  localparam int CODE_W = 3;
  localparam int ACT_W  = 2;
  localparam int CIDX_W = 2;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_DOWN   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_HOLD   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UP     = 2'd2;
  localparam logic [ACT_W-1:0] ACT_ATTACH = 2'd3;

  // Result codes
  localparam logic [CODE_W-1:0] CODE_DOWN   = 3'd0;
  localparam logic [CODE_W-1:0] CODE_UP     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_CLICK  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_LONG   = 3'd3;
  localparam logic [CODE_W-1:0] CODE_HOLD   = 3'd4;
  localparam logic [CODE_W-1:0] CODE_ATTACH = 3'd5;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_FIRST_ID  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SECOND_ID = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_GROUP_ID  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_NOTICE_ID = 2'd3;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] second_id;
    logic [ID_W-1:0] group_id;
    logic [ID_W-1:0] notice_id;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]   source;
    logic [CODE_W-1:0] code;
    logic [ID_W-1:0]   target;
    logic              last;
  } result_t;

  // 0, 1 or 2 results produced by one item
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic result_t mk_result(input logic [ID_W-1:0] src,
                                        input logic [CODE_W-1:0] code,
                                        input logic [ID_W-1:0] tgt,
                                        input logic last);
    result_t r;
    r.source = src;
    r.code   = code;
    r.target = tgt;
    r.last   = last;
    return r;
  endfunction

endpackage

// File: design/tbcc_cfg.sv
// ----------------------------------------------------------------------------
// tbcc_cfg
// Configuration register file: button, group and notice ids.
// ----------------------------------------------------------------------------
module tbcc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [tbcc_pkg::CIDX_W-1:0]   wr_index,
  input  logic [tbcc_pkg::ID_W-1:0]     wr_data,
  output tbcc_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_id  <= 16'd1;
      cfg.second_id <= 16'd2;
      cfg.group_id  <= 16'd3;
      cfg.notice_id <= 16'd4;
    end else if (wr_en) begin
      unique case (wr_index)
        tbcc_pkg::CFG_FIRST_ID:  cfg.first_id  <= wr_data;
        tbcc_pkg::CFG_SECOND_ID: cfg.second_id <= wr_data;
        tbcc_pkg::CFG_GROUP_ID:  cfg.group_id  <= wr_data;
        tbcc_pkg::CFG_NOTICE_ID: cfg.notice_id <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: design/tbcc_core.sv
// ----------------------------------------------------------------------------
// tbcc_core
// Input register, button flags and the single-pass chord decision.
// ----------------------------------------------------------------------------
module tbcc_core (
  input  logic                         clk,
  input  logic                         rst,
  input  tbcc_pkg::cfg_t               cfg,
  input  logic                         in_fire,
  input  logic [tbcc_pkg::ACT_W-1:0]   in_action,
  input  logic [tbcc_pkg::ID_W-1:0]    in_source,
  input  logic                         q_space,
  output logic                         busy,
  output logic                         push_en,
  output tbcc_pkg::push_t              push
);

  logic                       hold_valid;
  logic [tbcc_pkg::ACT_W-1:0] hold_action;
  logic [tbcc_pkg::ID_W-1:0]  hold_source;

  logic [1:0] pressed, held, suppressed;
  logic [1:0] pressed_next, held_next, suppressed_next;
  logic       attached, attached_next;

  logic       is_first, is_second, same_ids, oth_hi;
  logic [1:0] m_src, m_oth, p_set, h_set, s_tmp;
  logic       src_held;

  assign push_en = hold_valid && q_space;
  assign busy    = hold_valid && !q_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      pressed    <= 2'b00;
      held       <= 2'b00;
      suppressed <= 2'b00;
      attached   <= 1'b0;
    end else begin
      if (in_fire) begin
        hold_valid <= 1'b1;
      end else if (push_en) begin
        hold_valid <= 1'b0;
      end
      if (push_en) begin
        pressed    <= pressed_next;
        held       <= held_next;
        suppressed <= suppressed_next;
        attached   <= attached_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_action <= in_action;
      hold_source <= in_source;
    end
  end

  // Id matching; equal ids hit both bits, partner read falls back to bit 0
  assign is_first  = hold_source == cfg.first_id;
  assign is_second = hold_source == cfg.second_id;
  assign same_ids  = cfg.first_id == cfg.second_id;
  assign oth_hi    = is_first && !same_ids;
  assign m_src     = {is_second, is_first};
  assign m_oth     = is_first ? {1'b1, same_ids} : {same_ids, 1'b1};
  assign p_set     = pressed | m_src;
  assign h_set     = held | m_src;
  assign src_held  = is_first ? held[0] : (is_second ? held[1] : 1'b0);

  always_comb begin
    pressed_next    = pressed;
    held_next       = held;
    suppressed_next = suppressed;
    attached_next   = attached;
    s_tmp           = suppressed;
    push.count      = 2'd0;
    push.r0         = tbcc_pkg::mk_result(cfg.group_id, tbcc_pkg::CODE_DOWN, '0, 1'b1);
    push.r1         = tbcc_pkg::mk_result(cfg.group_id, tbcc_pkg::CODE_CLICK, '0, 1'b1);
    unique case (hold_action)
      tbcc_pkg::ACT_DOWN: begin
        pressed_next = p_set;
        if (oth_hi ? p_set[1] : p_set[0]) begin
          push.count = 2'd1;
        end
      end
      tbcc_pkg::ACT_HOLD: begin
        held_next = h_set;
        push.r0   = tbcc_pkg::mk_result(cfg.group_id, tbcc_pkg::CODE_HOLD, '0, 1'b1);
        if (oth_hi ? h_set[1] : h_set[0]) begin
          push.count = 2'd1;
        end
      end
      tbcc_pkg::ACT_UP: begin
        if (oth_hi ? pressed[1] : pressed[0]) begin
          // chord release: group up then group click / long click
          push.count = 2'd2;
          push.r0    = tbcc_pkg::mk_result(cfg.group_id, tbcc_pkg::CODE_UP, '0, 1'b0);
          if (src_held && (oth_hi ? held[1] : held[0])) begin
            push.r1 = tbcc_pkg::mk_result(cfg.group_id, tbcc_pkg::CODE_LONG, '0, 1'b1);
          end
          s_tmp = suppressed | m_oth;
        end else if (!(is_first ? suppressed[0] : (is_second ? suppressed[1] : 1'b0))
                     && attached) begin
          push.count = 2'd1;
          push.r0    = tbcc_pkg::mk_result(hold_source,
                         src_held ? tbcc_pkg::CODE_LONG : tbcc_pkg::CODE_CLICK, '0, 1'b1);
        end
        pressed_next    = pressed & ~m_src;
        held_next       = held & ~m_src;
        suppressed_next = s_tmp & ~m_src;
      end
      tbcc_pkg::ACT_ATTACH: begin
        push.count    = 2'd2;
        push.r0       = tbcc_pkg::mk_result(cfg.notice_id, tbcc_pkg::CODE_ATTACH,
                                            cfg.first_id, 1'b0);
        push.r1       = tbcc_pkg::mk_result(cfg.notice_id, tbcc_pkg::CODE_ATTACH,
                                            cfg.second_id, 1'b1);
        attached_next = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: design/tbcc_queue.sv
// ----------------------------------------------------------------------------
// tbcc_queue
// Small result queue: takes up to two results per cycle, sends one.
// ----------------------------------------------------------------------------
module tbcc_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push_en,
  input  tbcc_pkg::push_t                push,
  output logic                           space,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tbcc_pkg::result_t              head
);

  tbcc_pkg::result_t                 entry [tbcc_pkg::QDEPTH];
  logic [tbcc_pkg::QPTR_W-1:0]       rptr, wptr;
  logic [tbcc_pkg::QCNT_W-1:0]       count;
  logic [tbcc_pkg::QCNT_W-1:0]       count_next;
  logic                              pop;
  logic [1:0]                        n_in;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign head      = entry[rptr];
  assign n_in      = push_en ? push.count : 2'd0;

  // room for two results once this cycle's pop is counted
  assign space = (count - {{(tbcc_pkg::QCNT_W-1){1'b0}}, pop})
                 <= tbcc_pkg::QCNT_W'(tbcc_pkg::QDEPTH - 2);

  assign count_next = count + tbcc_pkg::QCNT_W'(n_in)
                      - {{(tbcc_pkg::QCNT_W-1){1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= '0;
      wptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      wptr  <= wptr + tbcc_pkg::QPTR_W'(n_in);
      if (pop) begin
        rptr <= rptr + tbcc_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      entry[wptr] <= push.r0;
    end
    if (n_in == 2'd2) begin
      entry[wptr + tbcc_pkg::QPTR_W'(1)] <= push.r1;
    end
  end

endmodule

// File: design/two_button_chord_combiner_unit.sv
// ----------------------------------------------------------------------------
// two_button_chord_combiner_unit
// Turns down/hold/up events of two sub-buttons into group-button events.
// ----------------------------------------------------------------------------
// Path: input stage register, then result queue, which drives the outputs.
// Throughput: one item per cycle for items with no or one result while the sink
//   keeps up; two results (chord release, attach) share the single output port.
// Reset (rst, synchronous, active high): ids return to 1/2/3/4, all button
//   flags and the attached flag clear, the input stage and result queue empty.
module two_button_chord_combiner_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tbcc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tbcc_pkg::ID_W-1:0]     cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tbcc_pkg::ACT_W-1:0]    action,
  input  logic [tbcc_pkg::ID_W-1:0]     source_id,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tbcc_pkg::ID_W-1:0]     out_source,
  output logic [tbcc_pkg::CODE_W-1:0]   out_code,
  output logic [tbcc_pkg::ID_W-1:0]     out_target,
  output logic                          last_of_run
);

  tbcc_pkg::cfg_t    cfg;
  tbcc_pkg::push_t   push;
  tbcc_pkg::result_t head;
  logic              core_busy;
  logic              push_en;
  logic              q_space;
  logic              in_fire;

  // Register writes are always taken and land; the user must only write while idle.
  assign cfg_ready = 1'b1;

  // The input stage frees up in the same cycle its item is pushed to the
  // queue, so ready stays high for single-result items while the sink keeps up.
  assign in_ready = !core_busy;
  assign in_fire  = in_valid && in_ready;

  tbcc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Holds one item, decides its results and updates the button flags when
  // the queue has room for two results.
  tbcc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .in_action (action),
    .in_source (source_id),
    .q_space   (q_space),
    .busy      (core_busy),
    .push_en   (push_en),
    .push      (push)
  );

  // Four-entry result queue parts the two sides; outputs come from its regs.
  tbcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (push_en),
    .push      (push),
    .space     (q_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_source  = head.source;
  assign out_code    = head.code;
  assign out_target  = head.target;
  assign last_of_run = head.last;

endmodule

// File: design/tbcc_checker.sv
// ----------------------------------------------------------------------------
// tbcc_checker
// Port-level checks for the chord combiner, bound to the top level.
// ----------------------------------------------------------------------------
module tbcc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tbcc_pkg::ID_W-1:0]     out_source,
  input logic [tbcc_pkg::CODE_W-1:0]   out_code,
  input logic [tbcc_pkg::ID_W-1:0]     out_target,
  input logic                          last_of_run
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_source) && $stable(out_code)
      && $stable(out_target) && $stable(last_of_run))
    else $error("result changed while stalled");

  // only attach notices name a target
  a_target_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_code != tbcc_pkg::CODE_ATTACH |-> out_target == '0)
    else $error("nonzero target on non-attach result");

  // first attach notice is followed at once by the closing one
  a_attach_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_code == tbcc_pkg::CODE_ATTACH && !last_of_run
      |=> out_valid && out_code == tbcc_pkg::CODE_ATTACH && last_of_run)
    else $error("attach notice pair broken");

  // group up is followed at once by group click or long click
  a_chord_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_code == tbcc_pkg::CODE_UP && !last_of_run
      |=> out_valid && last_of_run
          && (out_code == tbcc_pkg::CODE_CLICK || out_code == tbcc_pkg::CODE_LONG))
    else $error("group up not followed by click");

endmodule

bind two_button_chord_combiner_unit tbcc_checker u_tbcc_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-button chord combiner testbench
// Drives down/hold/up/attach items into the combiner and checks every result
// against an in-bench predictor of the chord logic. A directed pass covers
// chords, suppression, unknown sources, extreme and shared ids; a random pass
// runs press sequences under several id settings with random source gaps and
// sink stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int DRAIN_PAD      = 6;     // covers the input stage and queue plus margin
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 85;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [tbcc_pkg::CIDX_W-1:0]     cfg_index = tbcc_pkg::CFG_FIRST_ID;
  logic [tbcc_pkg::ID_W-1:0]       cfg_data  = '0;

  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  logic [tbcc_pkg::ACT_W-1:0]      action    = tbcc_pkg::ACT_DOWN;
  logic [tbcc_pkg::ID_W-1:0]       source_id = '0;

  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [tbcc_pkg::ID_W-1:0]       out_source;
  logic [tbcc_pkg::CODE_W-1:0]     out_code;
  logic [tbcc_pkg::ID_W-1:0]       out_target;
  logic                            last_of_run;

  two_button_chord_combiner_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .source_id   (source_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_source  (out_source),
    .out_code    (out_code),
    .out_target  (out_target),
    .last_of_run (last_of_run)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Chord predictor: ids and button flags as the block should hold them.
  // Flag bit 0 belongs to the first sub-button, bit 1 to the second.
  // --------------------------------------------------------------------------
  logic [tbcc_pkg::ID_W-1:0] id_first  = 16'd1;
  logic [tbcc_pkg::ID_W-1:0] id_second = 16'd2;
  logic [tbcc_pkg::ID_W-1:0] id_group  = 16'd3;
  logic [tbcc_pkg::ID_W-1:0] id_notice = 16'd4;
  logic [1:0]                btn_pressed    = 2'b00;
  logic [1:0]                btn_held       = 2'b00;
  logic [1:0]                btn_suppressed = 2'b00;
  logic                      group_attached = 1'b0;

  tbcc_pkg::result_t expected_events[$];

  // Run statistics and error count
  int n_mismatch = 0;
  int n_items    = 0;
  int n_results  = 0;
  int n_chords   = 0;
  int n_solo     = 0;
  int n_attach   = 0;
  int n_cfg      = 0;

  // Idle controls: source gaps and sink stalls, switched per phase
  logic src_gaps    = 1'b1;
  logic sink_stalls = 1'b1;

  // Flag lookup tries the first id before the second; unknown ids read as 0
  function automatic logic flag_of(input logic [1:0] flags,
                                   input logic [tbcc_pkg::ID_W-1:0] id);
    if (id == id_first) return flags[0];
    if (id == id_second) return flags[1];
    return 1'b0;
  endfunction

  // Both ids are tested, so shared ids touch both bits
  function automatic logic [1:0] with_flag(input logic [1:0] flags,
                                           input logic [tbcc_pkg::ID_W-1:0] id,
                                           input logic v);
    logic [1:0] f;
    f = flags;
    if (id == id_first) f[0] = v;
    if (id == id_second) f[1] = v;
    return f;
  endfunction

  function automatic tbcc_pkg::result_t chord_event(
      input logic [tbcc_pkg::ID_W-1:0]   src,
      input logic [tbcc_pkg::CODE_W-1:0] code,
      input logic [tbcc_pkg::ID_W-1:0]   tgt);
    tbcc_pkg::result_t r;
    r.source = src;
    r.code   = code;
    r.target = tgt;
    r.last   = 1'b0;
    return r;
  endfunction

  // Works out the results of one accepted item and queues them in order
  task automatic chord_predict(input logic [tbcc_pkg::ACT_W-1:0] act,
                               input logic [tbcc_pkg::ID_W-1:0] src);
    tbcc_pkg::result_t         evs[2];
    int                        n;
    logic [tbcc_pkg::ID_W-1:0] partner;
    n = 0;
    // a source that is not the first id pairs with the first button
    partner = (src == id_first) ? id_second : id_first;
    case (act)
      tbcc_pkg::ACT_DOWN: begin
        btn_pressed = with_flag(btn_pressed, src, 1'b1);
        if (flag_of(btn_pressed, partner)) begin
          evs[n] = chord_event(id_group, tbcc_pkg::CODE_DOWN, '0);
          n++;
        end
      end
      tbcc_pkg::ACT_HOLD: begin
        btn_held = with_flag(btn_held, src, 1'b1);
        if (flag_of(btn_held, partner)) begin
          evs[n] = chord_event(id_group, tbcc_pkg::CODE_HOLD, '0);
          n++;
        end
      end
      tbcc_pkg::ACT_UP: begin
        if (flag_of(btn_pressed, partner)) begin
          // chord release: group up, then click or long click
          evs[n] = chord_event(id_group, tbcc_pkg::CODE_UP, '0);
          n++;
          if (flag_of(btn_held, src) && flag_of(btn_held, partner))
            evs[n] = chord_event(id_group, tbcc_pkg::CODE_LONG, '0);
          else
            evs[n] = chord_event(id_group, tbcc_pkg::CODE_CLICK, '0);
          n++;
          btn_suppressed = with_flag(btn_suppressed, partner, 1'b1);
          n_chords++;
        end else if (!flag_of(btn_suppressed, src) && group_attached) begin
          // solo release goes out under the button's own id
          evs[n] = chord_event(src, flag_of(btn_held, src) ? tbcc_pkg::CODE_LONG
                                                           : tbcc_pkg::CODE_CLICK, '0);
          n++;
          n_solo++;
        end
        btn_pressed    = with_flag(btn_pressed, src, 1'b0);
        btn_held       = with_flag(btn_held, src, 1'b0);
        btn_suppressed = with_flag(btn_suppressed, src, 1'b0);
      end
      default: begin
        evs[0] = chord_event(id_notice, tbcc_pkg::CODE_ATTACH, id_first);
        evs[1] = chord_event(id_notice, tbcc_pkg::CODE_ATTACH, id_second);
        n = 2;
        group_attached = 1'b1;
        n_attach++;
      end
    endcase
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) evs[k].last = 1'b1;
      expected_events.push_back(evs[k]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [tbcc_pkg::ID_W-1:0] got,
                               input logic [tbcc_pkg::ID_W-1:0] want);
    $display("ERROR @%0t result %0d: %s got %h want %h", $realtime, n_results, what, got,
             want);
    n_mismatch++;
  endtask

  // Sink side: random stalls when enabled, otherwise always ready
  always @(posedge clk) begin
    out_ready <= sink_stalls ? ($urandom_range(99) >= 37) : 1'b1;
  end

  // Every accepted result is held against the oldest expectation
  always @(posedge clk) begin
    tbcc_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        note_mismatch("unexpected result, source", out_source, '0);
      end else begin
        want = expected_events.pop_front();
        if (out_source !== want.source) note_mismatch("out_source", out_source, want.source);
        if (out_code !== want.code)
          note_mismatch("out_code", tbcc_pkg::ID_W'(out_code), tbcc_pkg::ID_W'(want.code));
        if (out_target !== want.target) note_mismatch("out_target", out_target, want.target);
        if (last_of_run !== want.last)
          note_mismatch("last_of_run", tbcc_pkg::ID_W'(last_of_run),
                        tbcc_pkg::ID_W'(want.last));
      end
      n_results++;
    end
  end

  // Watchdog: a run that stops moving is a failure
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("two_button_chord_combiner_unit: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Sends one item; valid is left high so back-to-back items need no toggle
  task automatic send_item(input logic [tbcc_pkg::ACT_W-1:0] act,
                           input logic [tbcc_pkg::ID_W-1:0] src);
    while (src_gaps && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    source_id <= src;
    do @(posedge clk); while (!in_ready);
    chord_predict(act, src);
    n_items++;
  endtask

  // Writes one register; cfg_valid stays high for a following write
  task automatic write_reg(input logic [tbcc_pkg::CIDX_W-1:0] idx,
                           input logic [tbcc_pkg::ID_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tbcc_pkg::CFG_FIRST_ID:  id_first  = data;
      tbcc_pkg::CFG_SECOND_ID: id_second = data;
      tbcc_pkg::CFG_GROUP_ID:  id_group  = data;
      default:                 id_notice = data;
    endcase
    n_cfg++;
  endtask

  task automatic load_ids(input logic [tbcc_pkg::ID_W-1:0] f,
                          input logic [tbcc_pkg::ID_W-1:0] s,
                          input logic [tbcc_pkg::ID_W-1:0] g,
                          input logic [tbcc_pkg::ID_W-1:0] a);
    write_reg(tbcc_pkg::CFG_FIRST_ID, f);
    write_reg(tbcc_pkg::CFG_SECOND_ID, s);
    write_reg(tbcc_pkg::CFG_GROUP_ID, g);
    write_reg(tbcc_pkg::CFG_NOTICE_ID, a);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, let every expected result drain, then pad for items that
  // produce nothing but may still be in the pipe
  task automatic wait_drained;
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset ids 1/2/3/4: release before attach, chords, long chords,
  // suppression of the partner, solo clicks, unknown sources, extreme ids
  task automatic test_chords_default_ids;
    send_item(tbcc_pkg::ACT_UP, 16'd1);          // not attached: silent
    send_item(tbcc_pkg::ACT_DOWN, 16'd1);
    send_item(tbcc_pkg::ACT_DOWN, 16'd2);        // group down
    send_item(tbcc_pkg::ACT_HOLD, 16'd1);
    send_item(tbcc_pkg::ACT_HOLD, 16'd2);        // group hold
    send_item(tbcc_pkg::ACT_UP, 16'd1);          // group up + long click, 2 suppressed
    send_item(tbcc_pkg::ACT_UP, 16'd2);          // suppressed: silent
    send_item(tbcc_pkg::ACT_ATTACH, 16'hFFFF);   // two notices, source ignored
    send_item(tbcc_pkg::ACT_DOWN, 16'd2);
    send_item(tbcc_pkg::ACT_UP, 16'd2);          // solo click from 2
    send_item(tbcc_pkg::ACT_DOWN, 16'd1);
    send_item(tbcc_pkg::ACT_HOLD, 16'd1);
    send_item(tbcc_pkg::ACT_UP, 16'd1);          // solo long click from 1
    send_item(tbcc_pkg::ACT_DOWN, 16'd1);
    send_item(tbcc_pkg::ACT_DOWN, 16'd2);
    send_item(tbcc_pkg::ACT_UP, 16'd2);          // group up + click, 1 suppressed
    send_item(tbcc_pkg::ACT_UP, 16'd1);          // silent
    send_item(tbcc_pkg::ACT_DOWN, 16'd7);        // unknown id: partner is the first button
    send_item(tbcc_pkg::ACT_DOWN, 16'd1);
    send_item(tbcc_pkg::ACT_HOLD, 16'd7);
    send_item(tbcc_pkg::ACT_UP, 16'd7);          // first pressed: chord from unknown id
    send_item(tbcc_pkg::ACT_UP, 16'd1);
    send_item(tbcc_pkg::ACT_UP, 16'hFFFF);       // click under unknown id
    send_item(tbcc_pkg::ACT_HOLD, 16'h0000);
    send_item(tbcc_pkg::ACT_UP, 16'h0000);
  endtask

  // Extreme id values, then both buttons sharing one id
  task automatic test_extreme_and_shared_ids;
    wait_drained();
    load_ids(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_item(tbcc_pkg::ACT_ATTACH, 16'h0000);
    send_item(tbcc_pkg::ACT_DOWN, 16'h0000);
    send_item(tbcc_pkg::ACT_DOWN, 16'hFFFF);
    send_item(tbcc_pkg::ACT_HOLD, 16'hFFFF);
    send_item(tbcc_pkg::ACT_HOLD, 16'h0000);
    send_item(tbcc_pkg::ACT_UP, 16'hFFFF);
    send_item(tbcc_pkg::ACT_UP, 16'h0000);
    wait_drained();
    // shared id: one event sets both bits and the partner reads bit 0
    load_ids(16'h5A5A, 16'h5A5A, 16'h0000, 16'hFFFF);
    send_item(tbcc_pkg::ACT_DOWN, 16'h5A5A);
    send_item(tbcc_pkg::ACT_HOLD, 16'h5A5A);
    send_item(tbcc_pkg::ACT_UP, 16'h5A5A);
    send_item(tbcc_pkg::ACT_DOWN, 16'h5A5A);
    send_item(tbcc_pkg::ACT_UP, 16'h5A5A);
    send_item(tbcc_pkg::ACT_ATTACH, 16'hA5A5);
  endtask

  // Random press sequences: mostly well-formed down/hold/up runs on the two
  // buttons, some stray actions and unknown ids, rare attach actions
  task automatic test_random_presses;
    logic [tbcc_pkg::ID_W-1:0]  f, s;
    logic [1:0]                 is_down;
    logic [tbcc_pkg::ID_W-1:0]  src;
    logic [tbcc_pkg::ACT_W-1:0] act;
    int                         pick, roll, kind, b;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      kind = (p < 4) ? p : $urandom_range(3);
      case (kind)
        0: begin
          f = 16'($urandom_range(1, 8));
          s = 16'($urandom_range(9, 16));
        end
        1: begin
          f = 16'($urandom_range(65535));
          s = 16'($urandom_range(65535));
        end
        2: begin
          f = 16'($urandom_range(65535));
          s = f;
        end
        default: begin
          f = 16'hFFFF;
          s = 16'h0000;
        end
      endcase
      load_ids(f, s, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
      // phase 2 runs with no idling on either side
      src_gaps    = (p != 2);
      sink_stalls = (p != 2);
      is_down = 2'b00;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        roll = $urandom_range(99);
        if ($urandom_range(99) < 4) begin
          act = tbcc_pkg::ACT_ATTACH;
          src = 16'($urandom_range(65535));
        end else if (pick >= 92) begin
          // stray source id
          src = 16'($urandom_range(65535));
          act = (roll < 34) ? tbcc_pkg::ACT_DOWN :
                (roll < 67) ? tbcc_pkg::ACT_HOLD : tbcc_pkg::ACT_UP;
        end else begin
          b   = (pick < 46) ? 0 : 1;
          src = (b == 0) ? id_first : id_second;
          if (!is_down[b]) begin
            if (roll < 80) begin
              act = tbcc_pkg::ACT_DOWN;
              is_down[b] = 1'b1;
            end else begin
              act = (roll < 90) ? tbcc_pkg::ACT_HOLD : tbcc_pkg::ACT_UP;
            end
          end else if (roll < 35) begin
            act = tbcc_pkg::ACT_HOLD;
          end else if (roll < 85) begin
            act = tbcc_pkg::ACT_UP;
            is_down[b] = 1'b0;
          end else begin
            act = tbcc_pkg::ACT_DOWN;
          end
        end
        send_item(act, src);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_chords_default_ids();
    test_extreme_and_shared_ids();
    test_random_presses();
    wait_drained();
    $display("covered %0d items, %0d results, %0d register writes", n_items, n_results,
             n_cfg);
    $display("chord releases %0d, solo clicks %0d, attach actions %0d", n_chords, n_solo,
             n_attach);
    if (n_mismatch == 0) begin
      $display("two_button_chord_combiner_unit: match");
    end else begin
      $display("two_button_chord_combiner_unit: mismatch");
    end
    $finish;
  end

endmodule
